// ----- rtl/qte_pkg.sv -----
// qte_pkg: shared types, constants and helper functions for quaternion_to_euler
// no dependencies; used by every module of the block
package qte_pkg;

    localparam int QUAT_WIDTH      = 16;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int PITCH_W         = ANGLE_FRAC_BITS + 8;
    localparam int ANGLE_W         = ANGLE_FRAC_BITS + 9;
    localparam int NORM_BITS       = 25;
    localparam int NW              = NORM_BITS + 1;
    localparam int PW              = 2 * NW;
    localparam int CW              = 56;
    localparam int ZW              = 34;
    localparam int ACC_FRAC        = 24;
    localparam int RND_SHIFT       = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int CORDIC_STEPS    = 28;
    localparam int LEN_W           = $clog2(QUAT_WIDTH + 1);
    localparam int SHAMT_W         = 7;
    localparam int SPLIT           = 28;

    localparam logic [30:0] GAIN_Q30 = 31'd1768195363;

    typedef logic signed [CW-1:0] cval_t;
    typedef logic signed [ZW-1:0] zval_t;

    localparam zval_t DEG90  = zval_t'(90) <<< ACC_FRAC;
    localparam zval_t DEG180 = zval_t'(180) <<< ACC_FRAC;

    typedef struct packed {
        logic signed [QUAT_WIDTH-1:0] quat_x;
        logic signed [QUAT_WIDTH-1:0] quat_y;
        logic signed [QUAT_WIDTH-1:0] quat_z;
        logic signed [QUAT_WIDTH-1:0] quat_w;
    } quat_in_t;

    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch_deg;
        logic signed [ANGLE_W-1:0] yaw_deg;
        logic signed [ANGLE_W-1:0] roll_deg;
        logic                      zero_quat;
    } euler_out_t;

    typedef struct packed {
        logic                 zero;
        logic signed [NW-1:0] x;
        logic signed [NW-1:0] y;
        logic signed [NW-1:0] z;
        logic signed [NW-1:0] w;
    } norm_t;

    typedef struct packed {
        logic  zero;
        cval_t s;
        cval_t y1;
        cval_t y2;
        cval_t r1;
        cval_t r2;
    } terms_t;

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic zval_t atan_deg(input logic [4:0] idx);
        zval_t r;
        case (idx)
            5'd0:  r = zval_t'(754974720);
            5'd1:  r = zval_t'(445687602);
            5'd2:  r = zval_t'(235489088);
            5'd3:  r = zval_t'(119537938);
            5'd4:  r = zval_t'(60000934);
            5'd5:  r = zval_t'(30029717);
            5'd6:  r = zval_t'(15018523);
            5'd7:  r = zval_t'(7509720);
            5'd8:  r = zval_t'(3754917);
            5'd9:  r = zval_t'(1877466);
            5'd10: r = zval_t'(938734);
            5'd11: r = zval_t'(469367);
            5'd12: r = zval_t'(234684);
            5'd13: r = zval_t'(117342);
            5'd14: r = zval_t'(58671);
            5'd15: r = zval_t'(29335);
            5'd16: r = zval_t'(14668);
            5'd17: r = zval_t'(7334);
            5'd18: r = zval_t'(3667);
            5'd19: r = zval_t'(1833);
            5'd20: r = zval_t'(917);
            5'd21: r = zval_t'(458);
            5'd22: r = zval_t'(229);
            5'd23: r = zval_t'(115);
            5'd24: r = zval_t'(57);
            5'd25: r = zval_t'(29);
            5'd26: r = zval_t'(14);
            5'd27: r = zval_t'(7);
            default: r = '0;
        endcase
        return r;
    endfunction

    // clamp to +-lim, then round half up to the output fraction
    function automatic zval_t round_angle(input zval_t acc, input zval_t lim);
        zval_t c;
        c = acc;
        if (acc > lim) begin
            c = lim;
        end else if (acc < -lim) begin
            c = -lim;
        end
        return (c + (zval_t'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
    endfunction

endpackage

// ----- rtl/qte_norm.sv -----
// qte_norm: three-stage block scaling, largest component magnitude into [2^24, 2^25)
// depends on qte_pkg
module qte_norm (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  qte_pkg::quat_in_t in_data,
    output logic             out_valid,
    output qte_pkg::norm_t   out_data
);
    localparam int QW = qte_pkg::QUAT_WIDTH;
    localparam int EW = QW + qte_pkg::NORM_BITS + 1;

    logic signed [QW-1:0] c_in [4];
    logic [QW-1:0]        a_in [4];
    logic [QW-1:0]        m01, m23, mag_next;

    logic signed [QW-1:0] c1_reg [4];
    logic [QW-1:0]        mag1_reg;
    logic                 v1_reg;

    logic [qte_pkg::LEN_W-1:0] len_next;
    logic signed [QW-1:0]      c2_reg [4];
    logic [qte_pkg::LEN_W-1:0] len2_reg;
    logic                      zero2_reg;
    logic                      v2_reg;

    logic signed [qte_pkg::NW-1:0] n_next [4];
    qte_pkg::norm_t out_reg;
    logic           v3_reg;

    // stage 1: magnitudes and their maximum
    always_comb begin
        c_in[0] = in_data.quat_x;
        c_in[1] = in_data.quat_y;
        c_in[2] = in_data.quat_z;
        c_in[3] = in_data.quat_w;
        for (int k = 0; k < 4; k++) begin
            a_in[k] = c_in[k][QW-1] ? (~c_in[k] + 1'b1) : c_in[k];
        end
        m01      = (a_in[0] > a_in[1]) ? a_in[0] : a_in[1];
        m23      = (a_in[2] > a_in[3]) ? a_in[2] : a_in[3];
        mag_next = (m01 > m23) ? m01 : m23;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg   <= c_in;
            mag1_reg <= mag_next;
        end
    end

    // stage 2: bit length of the maximum
    always_comb begin
        len_next = '0;
        for (int i = 0; i < QW; i++) begin
            if (mag1_reg[i]) begin
                len_next = qte_pkg::LEN_W'(i + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c2_reg    <= c1_reg;
            len2_reg  <= len_next;
            zero2_reg <= (mag1_reg == '0);
        end
    end

    // stage 3: common shift of all four components
    always_comb begin
        logic signed [EW-1:0] ext;
        logic signed [EW-1:0] sh;
        for (int k = 0; k < 4; k++) begin
            ext = EW'(c2_reg[k]);
            if (qte_pkg::SHAMT_W'(len2_reg) <= qte_pkg::SHAMT_W'(qte_pkg::NORM_BITS)) begin
                sh = ext <<< (qte_pkg::SHAMT_W'(qte_pkg::NORM_BITS)
                              - qte_pkg::SHAMT_W'(len2_reg));
            end else begin
                sh = ext >>> (qte_pkg::SHAMT_W'(len2_reg)
                              - qte_pkg::SHAMT_W'(qte_pkg::NORM_BITS));
            end
            n_next[k] = sh[qte_pkg::NW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.zero <= zero2_reg;
            out_reg.x    <= n_next[0];
            out_reg.y    <= n_next[1];
            out_reg.z    <= n_next[2];
            out_reg.w    <= n_next[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

endmodule

// ----- rtl/qte_prod.sv -----
// qte_prod: two-stage products and sums forming the sine and cosine terms
// depends on qte_pkg
module qte_prod (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  qte_pkg::norm_t  in_data,
    output logic            out_valid,
    output qte_pkg::terms_t out_data
);
    localparam int PW = qte_pkg::PW;

    logic signed [PW-1:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [PW-1:0] wx_reg, zy_reg, wy_reg, xz_reg, wz_reg, xy_reg;
    logic                 zero_reg;
    logic                 v1_reg;

    qte_pkg::cval_t  n2;
    qte_pkg::terms_t out_next;
    qte_pkg::terms_t out_reg;
    logic            v2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            xx_reg   <= in_data.x * in_data.x;
            yy_reg   <= in_data.y * in_data.y;
            zz_reg   <= in_data.z * in_data.z;
            ww_reg   <= in_data.w * in_data.w;
            wx_reg   <= in_data.w * in_data.x;
            zy_reg   <= in_data.z * in_data.y;
            wy_reg   <= in_data.w * in_data.y;
            xz_reg   <= in_data.x * in_data.z;
            wz_reg   <= in_data.w * in_data.z;
            xy_reg   <= in_data.x * in_data.y;
            zero_reg <= in_data.zero;
        end
    end

    always_comb begin
        n2 = qte_pkg::cval_t'(xx_reg) + qte_pkg::cval_t'(yy_reg)
           + qte_pkg::cval_t'(zz_reg) + qte_pkg::cval_t'(ww_reg);
        out_next.zero = zero_reg;
        out_next.s  = (qte_pkg::cval_t'(wx_reg) - qte_pkg::cval_t'(zy_reg)) <<< 1;
        out_next.y1 = (qte_pkg::cval_t'(wy_reg) + qte_pkg::cval_t'(xz_reg)) <<< 1;
        out_next.y2 = n2 - ((qte_pkg::cval_t'(xx_reg) + qte_pkg::cval_t'(yy_reg)) <<< 1);
        out_next.r1 = (qte_pkg::cval_t'(wz_reg) + qte_pkg::cval_t'(xy_reg)) <<< 1;
        out_next.r2 = n2 - ((qte_pkg::cval_t'(yy_reg) + qte_pkg::cval_t'(zz_reg)) <<< 1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = out_reg;

endmodule

// ----- rtl/qte_cordic.sv -----
// qte_cordic: pipelined cordic vectoring, one register stage per iteration
// depends on qte_pkg; carries a sideband word alongside each transaction
module qte_cordic #(
    parameter int SIDE_W = 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  qte_pkg::cval_t     in_x,
    input  qte_pkg::cval_t     in_y,
    input  logic [SIDE_W-1:0]  in_side,
    output logic               out_valid,
    output qte_pkg::zval_t     out_angle,
    output qte_pkg::cval_t     out_mag,
    output logic [SIDE_W-1:0]  out_side
);
    localparam int STEPS = qte_pkg::CORDIC_STEPS;

    qte_pkg::cval_t    x_reg [0:STEPS];
    qte_pkg::cval_t    y_reg [0:STEPS];
    qte_pkg::zval_t    z_reg [0:STEPS];
    logic [SIDE_W-1:0] side_reg [0:STEPS];
    logic              v_reg [0:STEPS];

    qte_pkg::cval_t x0_next, y0_next;
    qte_pkg::zval_t z0_next;

    // left half plane: rotate by 180 degrees first
    always_comb begin
        if (in_x < 0) begin
            x0_next = -in_x;
            y0_next = -in_y;
            z0_next = (in_y >= 0) ? qte_pkg::DEG180 : -qte_pkg::DEG180;
        end else begin
            x0_next = in_x;
            y0_next = in_y;
            z0_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            z_reg[0]    <= z0_next;
            side_reg[0] <= in_side;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        qte_pkg::cval_t x_next, y_next;
        qte_pkg::zval_t z_next;

        always_comb begin
            if (!y_reg[i][qte_pkg::CW-1]) begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + qte_pkg::atan_deg(5'(i));
            end else begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - qte_pkg::atan_deg(5'(i));
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                side_reg[i+1] <= side_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (en) begin
                v_reg[i+1] <= v_reg[i];
            end
        end
    end

    assign out_valid = v_reg[STEPS];
    assign out_angle = z_reg[STEPS];
    assign out_mag   = x_reg[STEPS];
    assign out_side  = side_reg[STEPS];

endmodule

// ----- rtl/quaternion_to_euler.sv -----
// quaternion_to_euler: top level, quaternion to pitch/yaw/roll in degrees
// depends on qte_pkg, qte_norm, qte_prod, qte_cordic
//
// usage:
//   s_ channel carries one quaternion per transaction (x, y, z, w, signed
//   Q2.14); m_ channel returns pitch, yaw, roll (signed degrees, 7 fraction
//   bits) and a flag for the all-zero quaternion, which forces zero angles
//   path: normalize, products/sums, yaw and roll cordic (side by side),
//     gain multiply, pitch cordic, output register, each registered
//   throughput: one transaction per cycle unless a held result stalls
//   the pipeline; the pitch cordic needs the yaw magnitude, so the two
//   cordic arrays are chained, which sets the latency
//   reset: synchronous active-low aresetn clears every valid bit; data
//   registers are not reset
//   stall: when m_valid is high and m_ready low the whole pipeline holds
//   and s_ready drops; bubbles hold with it, so no transaction is lost
//   or repeated
module quaternion_to_euler (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  qte_pkg::quat_in_t     s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output qte_pkg::euler_out_t   m_data
);
    localparam int ZW       = qte_pkg::ZW;
    localparam int SPLIT    = qte_pkg::SPLIT;
    localparam int FULL_W   = qte_pkg::CW + 32;
    localparam int PITCH_SW = 1 + 2 * ZW;

    logic en;

    // normalize -> products
    logic           norm_valid;
    qte_pkg::norm_t norm_data;

    // products -> cordic
    logic            term_valid;
    qte_pkg::terms_t term_data;

    // yaw / roll cordic
    logic                    yaw_valid, roll_valid;
    qte_pkg::zval_t          yaw_angle, roll_angle;
    qte_pkg::cval_t          yaw_mag, roll_mag;
    logic [qte_pkg::CW:0]    yaw_side;
    logic                    roll_side;

    // gain multiply stages
    logic signed [SPLIT+31:0]  ph_reg;
    logic [SPLIT+30:0]         pl_reg;
    qte_pkg::cval_t            cmag1_reg;
    qte_pkg::zval_t            ya1_reg, ra1_reg;
    logic                      zero1_reg;
    logic                      g1_valid_reg;

    logic signed [FULL_W-1:0]  full_prod;
    qte_pkg::cval_t            sk_reg;
    qte_pkg::cval_t            cmag2_reg;
    qte_pkg::zval_t            ya2_reg, ra2_reg;
    logic                      zero2_reg;
    logic                      g2_valid_reg;

    // pitch cordic
    logic                 pitch_valid;
    qte_pkg::zval_t       pitch_angle;
    qte_pkg::cval_t       pitch_mag;
    logic [PITCH_SW-1:0]  pitch_side;

    // output register
    qte_pkg::euler_out_t out_next, out_reg;
    logic                m_valid_reg;
    qte_pkg::zval_t      pr, yr, rr;

    // the whole pipeline moves unless a finished result is held
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    qte_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (norm_valid),
        .out_data  (norm_data)
    );

    qte_prod u_prod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (norm_valid),
        .in_data   (norm_data),
        .out_valid (term_valid),
        .out_data  (term_data)
    );

    // yaw carries the sine term and zero flag along for the pitch path
    qte_cordic #(
        .SIDE_W (qte_pkg::CW + 1)
    ) u_yaw (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (term_valid),
        .in_x      (term_data.y2),
        .in_y      (term_data.y1),
        .in_side   ({term_data.zero, term_data.s}),
        .out_valid (yaw_valid),
        .out_angle (yaw_angle),
        .out_mag   (yaw_mag),
        .out_side  (yaw_side)
    );

    qte_cordic #(
        .SIDE_W (1)
    ) u_roll (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (term_valid),
        .in_x      (term_data.r2),
        .in_y      (term_data.r1),
        .in_side   (term_data.zero),
        .out_valid (roll_valid),
        .out_angle (roll_angle),
        .out_mag   (roll_mag),
        .out_side  (roll_side)
    );

    // sine term times cordic gain: split into two partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            ph_reg    <= $signed(yaw_side[qte_pkg::CW-1:SPLIT])
                         * $signed({1'b0, qte_pkg::GAIN_Q30});
            pl_reg    <= yaw_side[SPLIT-1:0] * qte_pkg::GAIN_Q30;
            cmag1_reg <= yaw_mag;
            ya1_reg   <= yaw_angle;
            ra1_reg   <= roll_angle;
            zero1_reg <= yaw_side[qte_pkg::CW];
        end
    end

    // floor of the full product over 2^30
    assign full_prod = (FULL_W'(ph_reg) <<< SPLIT) + $signed(FULL_W'(pl_reg));

    always_ff @(posedge aclk) begin
        if (en) begin
            sk_reg    <= full_prod[30 +: qte_pkg::CW];
            cmag2_reg <= cmag1_reg;
            ya2_reg   <= ya1_reg;
            ra2_reg   <= ra1_reg;
            zero2_reg <= zero1_reg;
        end
    end

    // pitch = atan2(sine * gain, yaw magnitude)
    qte_cordic #(
        .SIDE_W (PITCH_SW)
    ) u_pitch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (g2_valid_reg),
        .in_x      (cmag2_reg),
        .in_y      (sk_reg),
        .in_side   ({zero2_reg, ya2_reg, ra2_reg}),
        .out_valid (pitch_valid),
        .out_angle (pitch_angle),
        .out_mag   (pitch_mag),
        .out_side  (pitch_side)
    );

    // clamp, round, and force zeros for the all-zero quaternion
    always_comb begin
        pr = qte_pkg::round_angle(pitch_angle, qte_pkg::DEG90);
        yr = qte_pkg::round_angle(pitch_side[2*ZW-1:ZW], qte_pkg::DEG180);
        rr = qte_pkg::round_angle(pitch_side[ZW-1:0], qte_pkg::DEG180);
        out_next.zero_quat = pitch_side[2*ZW];
        if (pitch_side[2*ZW]) begin
            out_next.pitch_deg = '0;
            out_next.yaw_deg   = '0;
            out_next.roll_deg  = '0;
        end else begin
            out_next.pitch_deg = pr[qte_pkg::PITCH_W-1:0];
            out_next.yaw_deg   = yr[qte_pkg::ANGLE_W-1:0];
            out_next.roll_deg  = rr[qte_pkg::ANGLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g1_valid_reg <= 1'b0;
            g2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            g1_valid_reg <= yaw_valid;
            g2_valid_reg <= g1_valid_reg;
            m_valid_reg  <= pitch_valid;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // yaw and roll arrays run in lockstep
    a_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        yaw_valid == roll_valid)
        else $error("yaw and roll cordic valids diverged");

    // zero flag must come with zero angles
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_quat |->
            m_data.pitch_deg == '0 && m_data.yaw_deg == '0 && m_data.roll_deg == '0)
        else $error("zero quaternion with nonzero angles");

    // pitch stays within +-90 degrees
    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $signed(m_data.pitch_deg) <= $signed(15'sd11520)
                 && $signed(m_data.pitch_deg) >= -$signed(15'sd11520))
        else $error("pitch out of range");

    // a held result blocks new input
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while output stalled");

    // unused roll and pitch cordic magnitudes stay non-negative
    a_roll_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        roll_valid && !roll_side |-> roll_mag >= 0 && pitch_mag >= 0 || !pitch_valid)
        else $error("cordic magnitude went negative");

endmodule

// ----- verif/qte_checker.sv -----
`timescale 1ns / 1ps
// qte_checker: watches both channels of quaternion_to_euler, predicts each result
// from the accepted quaternion and compares; depends on qte_pkg
module qte_checker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  qte_pkg::quat_in_t     s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  qte_pkg::euler_out_t   m_data,
    output int                    errors,
    output int                    pending
);
    localparam longint ANG90  = 64'sd90 <<< 24;
    localparam longint ANG180 = 64'sd180 <<< 24;
    localparam longint K_GAIN = 64'sd1768195363;

    qte_pkg::euler_out_t angles_q[$];

    function automatic longint atan_step(input int i);
        longint t[28] = '{754974720, 445687602, 235489088, 119537938, 60000934,
            30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367,
            234684, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458,
            229, 115, 57, 29, 14, 7};
        return t[i];
    endfunction

    // vectoring rotation, returns angle and leaves magnitude in mag
    function automatic longint vector_angle(input longint vx, input longint vy,
                                            output longint mag);
        longint acc, dx, dy;
        acc = 0;
        if (vx < 0) begin
            acc = (vy >= 0) ? ANG180 : -ANG180;
            vx = -vx;
            vy = -vy;
        end
        for (int i = 0; i < 28; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0) begin
                vx += dx; vy -= dy; acc += atan_step(i);
            end else begin
                vx -= dx; vy += dy; acc -= atan_step(i);
            end
        end
        mag = vx;
        return acc;
    endfunction

    function automatic longint scale_gain(input longint v);
        longint hi, lo;
        longint unsigned p;
        hi = v >>> 30;
        lo = v - (hi <<< 30);
        p = (longint'(lo) * K_GAIN) >> 30;
        return hi * K_GAIN + longint'(p);
    endfunction

    function automatic longint round_deg(input longint acc, input longint lim);
        if (acc > lim) acc = lim;
        if (acc < -lim) acc = -lim;
        return (acc + (64'sd1 <<< 16)) >>> 17;
    endfunction

    function automatic qte_pkg::euler_out_t predict_angles(input qte_pkg::quat_in_t q);
        qte_pkg::euler_out_t r;
        longint c[4];
        longint mx, x, y, z, w, n2, s, y1, y2, r1, r2, cmag, dummy, pa, ya, ra;
        int len;
        c[0] = q.quat_x; c[1] = q.quat_y; c[2] = q.quat_z; c[3] = q.quat_w;
        mx = 0;
        foreach (c[k]) if ((c[k] < 0 ? -c[k] : c[k]) > mx) mx = c[k] < 0 ? -c[k] : c[k];
        r = '0;
        if (mx == 0) begin
            r.zero_quat = 1'b1;
            return r;
        end
        len = 0;
        while ((mx >> len) != 0) len++;
        foreach (c[k]) c[k] = c[k] <<< (25 - len);
        x = c[0]; y = c[1]; z = c[2]; w = c[3];
        n2 = x*x + y*y + z*z + w*w;
        s  = 2 * (w*x - z*y);
        y1 = 2 * (w*y + x*z);
        y2 = n2 - 2 * (x*x + y*y);
        r1 = 2 * (w*z + x*y);
        r2 = n2 - 2 * (y*y + z*z);
        ya = vector_angle(y2, y1, cmag);
        ra = vector_angle(r2, r1, dummy);
        pa = vector_angle(cmag, scale_gain(s), dummy);
        r.pitch_deg = qte_pkg::PITCH_W'(round_deg(pa, ANG90));
        r.yaw_deg   = qte_pkg::ANGLE_W'(round_deg(ya, ANG180));
        r.roll_deg  = qte_pkg::ANGLE_W'(round_deg(ra, ANG180));
        return r;
    endfunction

    assign pending = angles_q.size();

    always @(posedge aclk) begin
        qte_pkg::euler_out_t e;
        int bad;
        bad = 0;
        if (!aresetn) begin
            errors <= 0;
        end else begin
            if (s_valid && s_ready) begin
                angles_q.push_back(predict_angles(s_data));
            end
            if (m_valid && m_ready) begin
                if (angles_q.size() == 0) begin
                    $error("result with nothing expected");
                    bad++;
                end else begin
                    e = angles_q.pop_front();
                    if (m_data.pitch_deg !== e.pitch_deg) begin
                        $error("pitch_deg expected %0d got %0d", e.pitch_deg, m_data.pitch_deg);
                        bad++;
                    end
                    if (m_data.yaw_deg !== e.yaw_deg) begin
                        $error("yaw_deg expected %0d got %0d", e.yaw_deg, m_data.yaw_deg);
                        bad++;
                    end
                    if (m_data.roll_deg !== e.roll_deg) begin
                        $error("roll_deg expected %0d got %0d", e.roll_deg, m_data.roll_deg);
                        bad++;
                    end
                    if (m_data.zero_quat !== e.zero_quat) begin
                        $error("zero_quat expected %0d got %0d", e.zero_quat, m_data.zero_quat);
                        bad++;
                    end
                end
            end
            errors <= errors + bad;
        end
    end
endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// tb: stimulus and verdict for quaternion_to_euler
// depends on qte_pkg, quaternion_to_euler and qte_checker
module tb;
    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    qte_pkg::quat_in_t   s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    qte_pkg::euler_out_t m_data;
    int                  errors;
    int                  pending;
    int                  cycles = 0;
    logic                stim_done = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    quaternion_to_euler uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    qte_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .errors(errors), .pending(pending)
    );

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // random-stall stretches alternate with no-stall stretches
    logic no_idle = 1'b0;
    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0) no_idle <= ~no_idle;
    end

    // result side: random backpressure
    int sink_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (sink_gap > 0 && !no_idle) begin
            m_ready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else begin
            m_ready <= 1'b1;
            sink_gap <= pick_gap();
        end
    end

    // push one quaternion transaction, with an optional gap before it
    task automatic send_quat(input logic [15:0] qx, qy, qz, qw);
        int g;
        g = no_idle ? 0 : pick_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{quat_x: qx, quat_y: qy, quat_z: qz, quat_w: qw};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // random component by mode: full range, +-16384, +-32 or +-1024
    function automatic logic [15:0] rand_comp(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 32768)) - 16384);
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($signed($urandom_range(0, 2048)) - 1024);
        endcase
    endfunction

    initial begin
        logic [15:0] a, b;
        int mode;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero quaternion, identity, extremes, axis rotations,
        // gimbal lock both ways, negative cosine terms
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h4000);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'hC000);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_quat(16'h0001, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        send_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h0000, 16'h4000, 16'h0000, 16'h0000);
        send_quat(16'h0000, 16'h0000, 16'h4000, 16'h0000);
        send_quat(16'h2D41, 16'h0000, 16'h0000, 16'h2D41);
        send_quat(16'hD2BF, 16'h0000, 16'h0000, 16'h2D41);
        send_quat(16'h2000, 16'h2000, 16'hE000, 16'h2000);
        send_quat(16'h2000, 16'hE000, 16'h2000, 16'h2000);
        send_quat(16'h2D41, 16'h0000, 16'h0000, 16'hD2BF);
        send_quat(16'h0000, 16'h2D41, 16'h2D41, 16'h0000);
        send_quat(16'h1000, 16'h3000, 16'h0001, 16'hFFFF);
        send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);

        // hold off until the pipeline drains
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);

        for (int n = 0; n < 1200; n++) begin
            mode = $urandom_range(0, 9);
            if (mode < 3) begin
                send_quat(rand_comp(0), rand_comp(0), rand_comp(0), rand_comp(0));
            end else if (mode < 7) begin
                send_quat(rand_comp(1), rand_comp(1), rand_comp(1), rand_comp(1));
            end else if (mode == 7) begin
                send_quat(rand_comp(2), rand_comp(2), rand_comp(2), rand_comp(2));
            end else if (mode == 8) begin
                // near gimbal lock: w ~ x, y ~ -z
                a = rand_comp(1);
                b = rand_comp(1);
                send_quat(a, b, -b + rand_comp(2), a + rand_comp(2));
            end else begin
                send_quat(rand_comp(3), rand_comp(0), rand_comp(3), rand_comp(3));
            end
        end
        s_valid <= 1'b0;
        stim_done <= 1'b1;
    end

    // verdict: wait for drain plus pipeline latency, or time out
    int tail = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (stim_done && pending == 0) tail <= tail + 1;
        if (cycles > 400000) begin
            $display("FAIL quaternion_to_euler");
            $finish;
        end else if (tail == 100) begin
            if (errors == 0) begin
                $display("PASS quaternion_to_euler");
            end else begin
                $display("FAIL quaternion_to_euler");
            end
            $finish;
        end
    end
endmodule
